// ----- src/firlp_pkg.sv -----
// Shared types, widths and the Q0.16 coefficient table of the 25-tap low-pass FIR.
// No dependencies; imported by every module of the filter.
package firlp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W + 1;  // signed sample x unsigned coefficient
    localparam int FRAC_W    = 16;                     // Q0.16 coefficients
    localparam int MIN_ACC_W = 40;
    localparam int TABLE_LEN = 25;
    localparam int GROUP     = 8;                      // products summed per first-level adder
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic        [COEF_W-1:0]   t_coef;

    // Blackman window, symmetric; the end taps round to zero.
    localparam t_coef COEF_TABLE [TABLE_LEN] = '{
        16'd0,    16'd41,   16'd175,  16'd432,  16'd845,  16'd1439, 16'd2211,
        16'd3122, 16'd4096, 16'd5029, 16'd5806, 16'd6321, 16'd6502, 16'd6321,
        16'd5806, 16'd5029, 16'd4096, 16'd3122, 16'd2211, 16'd1439, 16'd845,
        16'd432,  16'd175,  16'd41,   16'd0
    };

    // Coefficient for tap n; taps beyond the table are zero.
    function automatic t_coef coef_at(input int n);
        t_coef c;
        c = '0;
        if (n < TABLE_LEN) begin
            c = COEF_TABLE[n];
        end
        return c;
    endfunction

endpackage

// ----- src/fir_lowpass_25_tap.sv -----
// Top level of the 25-tap Blackman-window low-pass FIR for encoder speed samples.
// Depends on firlp_pkg, firlp_taps, firlp_tree and firlp_round.
//
// Direct-form low-pass FIR: each accepted beat on the slave side shifts one signed 16-bit
// sample into a delay line (all zeros after reset) and produces exactly one beat on the
// master side, the dot product of the fixed Q0.16 coefficients with the newest TAPS samples
// (coefficient 0 on the newest), rounded half up and saturated to signed 16 bits. The DC
// gain is one. Throughput is one sample per clock unless the master side stalls. The input
// beat loads the delay-line register; the product registers, two adder tree levels and the
// round/saturate output register then follow in that order, and o_m_tvalid is driven from
// the output register. Each stage has its own valid bit, so bubbles are squeezed out and
// input is still taken while a result waits at the master side if any stage is empty.
// Taps past the 25-entry table carry a zero coefficient. No configuration.
module fir_lowpass_25_tap
    import firlp_pkg::*;
#(
    parameter int TAPS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: input samples
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample_in
    // master side: filtered samples
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] filtered_out
);

    // exact accumulator width, never under 40 bits
    localparam int SUM_W = PROD_W + $clog2(TAPS);
    localparam int ACC_W = (SUM_W > MIN_ACC_W) ? SUM_W : MIN_ACC_W;

    t_prod                   w_prod [TAPS];
    logic                    w_prod_valid;
    logic                    w_prod_ready;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_acc_valid;
    logic                    w_acc_ready;
    t_sample                 w_out;

    // delay line and constant multipliers
    firlp_taps #(
        .TAPS (TAPS)
    ) u_taps (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_sample ($signed(i_s_tdata)),
        .o_valid  (w_prod_valid),
        .i_ready  (w_prod_ready),
        .o_prod   (w_prod)
    );

    // registered adder tree
    firlp_tree #(
        .TAPS  (TAPS),
        .ACC_W (ACC_W)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prod_valid),
        .o_ready (w_prod_ready),
        .i_prod  (w_prod),
        .o_valid (w_acc_valid),
        .i_ready (w_acc_ready),
        .o_acc   (w_acc)
    );

    // rounding, clamp and output register
    firlp_round #(
        .ACC_W (ACC_W)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc_valid),
        .o_ready (w_acc_ready),
        .i_acc   (w_acc),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out)
    );

    assign o_m_tdata = w_out;

endmodule

// ----- src/firlp_taps.sv -----
// Delay line (input register) and per-tap constant products of the low-pass FIR.
// Depends on firlp_pkg.
module firlp_taps
    import firlp_pkg::*;
#(
    parameter int TAPS = 25
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_sample i_sample,
    output logic    o_valid,
    input  logic    i_ready,
    output t_prod   o_prod [TAPS]
);

    t_sample r_taps [TAPS];
    logic    r_v0;
    t_prod   r_prod [TAPS];
    t_prod   n_prod [TAPS];
    logic    r_v1;
    logic    w_rdy0;
    logic    w_rdy1;
    logic    w_fire;

    assign w_rdy1  = !r_v1 || i_ready;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign w_fire  = i_valid && w_rdy0;
    assign o_ready = w_rdy0;
    assign o_valid = r_v1;
    assign o_prod  = r_prod;

    // tap 0 is the newest sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_taps[k] <= '0;
            end
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_fire) begin
                r_taps[0] <= i_sample;
                for (int k = 1; k < TAPS; k++) begin
                    r_taps[k] <= r_taps[k-1];
                end
            end
            if (w_rdy0) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
        end
    end

    // constant multipliers, one per tap
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            n_prod[k] = $signed({1'b0, coef_at(k)}) * r_taps[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && r_v0) begin
            r_prod <= n_prod;
        end
    end

    a_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_taps[0] == $past(i_sample))
        else $error("newest tap does not hold the accepted sample");

    a_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_taps[TAPS-1] == $past(r_taps[TAPS-2]))
        else $error("delay line did not shift by one on a beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && !w_rdy1) |=> (r_v0 && $stable(r_taps[0])))
        else $error("window changed while waiting for the product stage");

endmodule

// ----- src/firlp_tree.sv -----
// Two-level registered adder tree summing the tap products of the low-pass FIR.
// Depends on firlp_pkg.
module firlp_tree
    import firlp_pkg::*;
#(
    parameter int TAPS  = 25,
    parameter int ACC_W = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_prod                   i_prod [TAPS],
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [ACC_W-1:0] o_acc
);

    localparam int NG = (TAPS + GROUP - 1) / GROUP;

    logic signed [ACC_W-1:0] w_term [NG][GROUP];
    logic signed [ACC_W-1:0] n_grp  [NG];
    logic signed [ACC_W-1:0] r_grp  [NG];
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_v2;
    logic                    r_v3;
    logic                    w_rdy2;
    logic                    w_rdy3;

    for (genvar g = 0; g < NG; g++) begin : g_grp
        for (genvar k = 0; k < GROUP; k++) begin : g_term
            if (g * GROUP + k < TAPS) begin : g_used
                assign w_term[g][k] = ACC_W'(i_prod[g*GROUP+k]);
            end else begin : g_pad
                assign w_term[g][k] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                n_grp[g] = n_grp[g] + w_term[g][k];
            end
        end
        n_acc = '0;
        for (int g = 0; g < NG; g++) begin
            n_acc = n_acc + r_grp[g];
        end
    end

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = w_rdy2;
    assign o_valid = r_v3;
    assign o_acc   = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_v2 <= i_valid;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && i_valid) begin
            r_grp <= n_grp;
        end
        if (w_rdy3 && r_v2) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ----- src/firlp_round.sv -----
// Round-half-up, saturation to signed 16 bits and the output register of the FIR.
// Depends on firlp_pkg.
module firlp_round
    import firlp_pkg::*;
#(
    parameter int ACC_W = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_sample                 o_data
);

    localparam int Q_W = ACC_W - FRAC_W;

    logic signed [ACC_W-1:0] w_biased;
    logic signed [Q_W-1:0]   w_q;
    t_sample                 n_data;
    t_sample                 r_data;
    logic                    r_valid;
    logic                    w_rdy;

    // add one half, then floor
    assign w_biased = i_acc + ACC_W'(1 << (FRAC_W - 1));
    assign w_q      = $signed(w_biased[ACC_W-1:FRAC_W]);

    always_comb begin
        priority if (w_q > Q_W'(SAMPLE_MAX)) begin
            n_data = SAMPLE_W'(SAMPLE_MAX);
        end else if (w_q < Q_W'(SAMPLE_MIN)) begin
            n_data = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            n_data = w_q[SAMPLE_W-1:0];
        end
    end

    assign w_rdy   = !r_valid || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_rdy) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
